/* hdl/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg: shared types, constants and helpers for the pointer packet tracker
// Transfer structs, screen geometry, controller byte fields and clamp functions.
// ----------------------------------------------------------------------------
package ppt_pkg;

  // Screen geometry
  localparam int unsigned ScreenW = 640;
  localparam int unsigned ScreenH = 480;
  localparam int unsigned CurXW   = $clog2(ScreenW);
  localparam int unsigned CurYW   = $clog2(ScreenH);

  // Width of the signed intermediate used for moves and clamps
  localparam int unsigned SumW = 17;

  // Output field widths
  localparam int unsigned PosXW = 10;
  localparam int unsigned PosYW = 9;

  // Header byte bit positions
  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;

  // Operation and source codes
  localparam logic OpMouse  = 1'b0;
  localparam logic OpTouch  = 1'b1;
  localparam logic SrcMouse = 1'b0;
  localparam logic SrcTouch = 1'b1;

  // Position within a three-byte mouse packet
  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhXDelta = 2'd1,
    PhYDelta = 2'd2
  } ppt_phase_e;

  // Input transfer
  typedef struct packed {
    logic               op;
    logic [7:0]         data_byte;
    logic               from_aux;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
    logic               touch_down;
    logic [31:0]        touch_taps;
  } ppt_in_t;

  // Result transfer
  typedef struct packed {
    logic [PosXW-1:0] pos_x;
    logic [PosYW-1:0] pos_y;
    logic             button_down;
    logic             clicked;
    logic             source;
  } ppt_out_t;

  // Flow control from the update stage to the register stages
  typedef struct packed {
    logic take;   // item in the input register is consumed this cycle
    logic emit;   // a result is loaded into the result register this cycle
  } ppt_flow_t;

  // Clamp a signed coordinate to 0 .. ScreenW-1
  function automatic logic [CurXW-1:0] clamp_x(input logic signed [SumW-1:0] v);
    logic [CurXW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SumW'(ScreenW - 1))) begin
      r = CurXW'(ScreenW - 1);
    end else begin
      r = v[CurXW-1:0];
    end
    return r;
  endfunction

  // Clamp a signed coordinate to 0 .. ScreenH-1
  function automatic logic [CurYW-1:0] clamp_y(input logic signed [SumW-1:0] v);
    logic [CurYW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SumW'(ScreenH - 1))) begin
      r = CurYW'(ScreenH - 1);
    end else begin
      r = v[CurYW-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/ppt_in_reg.sv */
// ----------------------------------------------------------------------------
// ppt_in_reg: input register
// Holds one accepted item until the update stage consumes it.
// ----------------------------------------------------------------------------
module ppt_in_reg import ppt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ppt_in_t   in_data_i,
  input  ppt_flow_t flow_i,
  output logic      item_valid_o,
  output ppt_in_t   item_o
);

  logic    valid_q, valid_d;
  ppt_in_t item_q;
  logic    load;

  // Free when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || flow_i.take;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !flow_i.take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* hdl/ppt_update.sv */
// ----------------------------------------------------------------------------
// ppt_update: pointer state and single-pass update
// Decodes controller bytes into packets, applies moves or touch samples,
// clamps to the screen and detects clicks.
// ----------------------------------------------------------------------------
module ppt_update import ppt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  ppt_in_t   item_i,
  input  logic      out_free_i,
  output ppt_flow_t flow_o,
  output ppt_out_t  result_o
);

  logic [CurXW-1:0] cursor_x_q, cursor_x_d;
  logic [CurYW-1:0] cursor_y_q, cursor_y_d;
  logic             pressed_q, pressed_d;
  logic             prev_pressed_q, prev_pressed_d;
  ppt_phase_e       phase_q, phase_d;
  logic [7:0]       header_q, header_d;
  logic [7:0]       xdelta_q, xdelta_d;
  logic [31:0]      last_taps_q, last_taps_d;

  logic                  has_result;
  logic                  take;
  logic                  clicked;
  logic signed [SumW-1:0] dx, dy, sum_x, sum_y;
  logic [12:0]           x_ext;
  logic [12:0]           y_ext;

  // 9-bit signed deltas, sign from the header byte
  assign dx    = SumW'($signed({header_q[HdrXSignBit], xdelta_q}));
  assign dy    = SumW'($signed({header_q[HdrYSignBit], item_i.data_byte}));
  assign sum_x = $signed(SumW'(cursor_x_q)) + dx;
  assign sum_y = $signed(SumW'(cursor_y_q)) - dy;

  // Does this item complete an update?
  always_comb begin
    if (item_i.op == OpTouch) begin
      has_result = 1'b1;
    end else begin
      has_result = item_i.from_aux && (phase_q != PhHeader) && (phase_q != PhXDelta);
    end
  end

  assign take   = item_valid_i && (!has_result || out_free_i);
  assign flow_o = '{take: take, emit: take && has_result};

  // Next state
  always_comb begin
    cursor_x_d     = cursor_x_q;
    cursor_y_d     = cursor_y_q;
    pressed_d      = pressed_q;
    prev_pressed_d = prev_pressed_q;
    phase_d        = phase_q;
    header_d       = header_q;
    xdelta_d       = xdelta_q;
    last_taps_d    = last_taps_q;
    clicked        = 1'b0;
    if (item_i.op == OpTouch) begin
      cursor_x_d  = clamp_x(SumW'(item_i.touch_x));
      cursor_y_d  = clamp_y(SumW'(item_i.touch_y));
      pressed_d   = item_i.touch_down;
      clicked     = (item_i.touch_taps != last_taps_q);
      last_taps_d = item_i.touch_taps;
    end else if (item_i.from_aux) begin
      unique case (phase_q)
        PhHeader: begin
          // Resync: a packet only starts on a byte with the sync bit set
          if (item_i.data_byte[HdrSyncBit]) begin
            header_d = item_i.data_byte;
            phase_d  = PhXDelta;
          end
        end
        PhXDelta: begin
          xdelta_d = item_i.data_byte;
          phase_d  = PhYDelta;
        end
        default: begin
          // Final byte: apply the move, screen y grows downward
          phase_d        = PhHeader;
          cursor_x_d     = clamp_x(sum_x);
          cursor_y_d     = clamp_y(sum_y);
          pressed_d      = header_q[HdrLeftBit];
          clicked        = header_q[HdrLeftBit] && !prev_pressed_q;
          prev_pressed_d = header_q[HdrLeftBit];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q     <= CurXW'(ScreenW / 2);
      cursor_y_q     <= CurYW'(ScreenH / 2);
      pressed_q      <= 1'b0;
      prev_pressed_q <= 1'b0;
      phase_q        <= PhHeader;
      last_taps_q    <= '0;
    end else if (take) begin
      cursor_x_q     <= cursor_x_d;
      cursor_y_q     <= cursor_y_d;
      pressed_q      <= pressed_d;
      prev_pressed_q <= prev_pressed_d;
      phase_q        <= phase_d;
      last_taps_q    <= last_taps_d;
    end
  end

  // Packet bytes need no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      header_q <= header_d;
      xdelta_q <= xdelta_d;
    end
  end

  // Result fields, positions masked to the output widths
  assign x_ext = 13'(cursor_x_d);
  assign y_ext = 13'(cursor_y_d);

  always_comb begin
    result_o.pos_x       = x_ext[PosXW-1:0];
    result_o.pos_y       = y_ext[PosYW-1:0];
    result_o.button_down = pressed_d;
    result_o.clicked     = clicked;
    result_o.source      = (item_i.op == OpTouch) ? SrcTouch : SrcMouse;
  end

endmodule

/* hdl/ppt_out_reg.sv */
// ----------------------------------------------------------------------------
// ppt_out_reg: result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ppt_out_reg import ppt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ppt_flow_t flow_i,
  input  ppt_out_t  result_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ppt_out_t  out_data_o
);

  logic     valid_q, valid_d;
  ppt_out_t data_q;

  // Room for a new result when empty or draining this cycle
  assign out_free_o = !valid_q || out_ready_i;
  assign valid_d    = flow_i.emit || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.emit) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* hdl/pointer_packet_tracker.sv */
// ----------------------------------------------------------------------------
// pointer_packet_tracker: screen pointer from mouse packets and touch samples
// Top level: input register, update stage and result register.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless a stalled consumer holds
// back the result register. Each item is held in the input register, then a
// single update pass (packet decode, add, clamp, click detect) writes the
// result register. Controller bytes that are not from the aux port,
// unsynchronized header bytes and the first two bytes of a packet give no
// result. A touch sample or a completed three-byte packet gives exactly one.
module pointer_packet_tracker import ppt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ppt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ppt_out_t out_data_o
);

  ppt_flow_t flow;
  logic      item_valid;
  ppt_in_t   item;
  logic      out_free;
  ppt_out_t  result;

  ppt_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .flow_i       (flow),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ppt_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .flow_o       (flow),
    .result_o     (result)
  );

  ppt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/ppt_checker.sv */
// ----------------------------------------------------------------------------
// ppt_checker: port-level checks for the pointer packet tracker
// Watches the result channel for stability and field consistency.
// ----------------------------------------------------------------------------
module ppt_checker import ppt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input ppt_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input ppt_out_t out_data_o
);

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Positions stay on screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.pos_x) <= ScreenW - 1) &&
                    (32'(out_data_o.pos_y) <= ScreenH - 1))
    else $error("position off screen");

  // A mouse click is a press edge, so the button must be down
  a_mouse_click: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.source == SrcMouse) && out_data_o.clicked
      |-> out_data_o.button_down)
    else $error("mouse click without button down");

  // A touch transfer into an empty pipe passes through both registers to the output
  a_touch_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OpTouch) && !out_valid_o
      |=> ##1 out_valid_o)
    else $error("touch sample gave no result");

endmodule

bind pointer_packet_tracker ppt_checker u_ppt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
